### rtl/core/ibtt_pkg.sv
`timescale 1ns / 1ps

package ibtt_pkg;

   // coordinate and arithmetic widths
   localparam int CoordBits = 12;
   localparam int AreaBits  = 2 * CoordBits + 1;   // signed box area
   localparam int WideBits  = 2 * CoordBits + 4;   // union and 5*inter
   localparam int CountBits = 8;
   localparam int IdBits    = 6;

   // csr word index of the history limit register
   localparam logic CsrHistoryLimit = 1'b0;
   localparam logic [CountBits-1:0] LimitReset = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // one tracked box with its count and precomputed area
   typedef struct packed {
      logic [CoordBits-1:0]       x1;
      logic [CoordBits-1:0]       y1;
      logic [CoordBits-1:0]       x2;
      logic [CoordBits-1:0]       y2;
      logic [CountBits-1:0]       count;
      logic signed [AreaBits-1:0] area;
   } entry_type;

   // per-cell controls
   typedef struct packed {
      logic shift;
      logic tick;
      logic write;
   } cell_ctl_type;

endpackage

### rtl/core/ibtt_cell.sv
`timescale 1ns / 1ps

module ibtt_cell
   import ibtt_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    nbr_in,
   input  entry_type    wr_data,
   output entry_type    entry_out
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.write) begin
         entry_in = wr_data;
      end else if (ctl.shift) begin
         entry_in = nbr_in;
      end else if (ctl.tick && (entry_ff.count != '0)) begin
         entry_in.count = entry_ff.count - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

### rtl/core/ibtt_iou.sv
`timescale 1ns / 1ps

module ibtt_iou
   import ibtt_pkg::*;
#(
   parameter int IDX_W = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   input  logic [IDX_W-1:0]     idx_in,
   input  entry_type            head,
   input  entry_type            cand,
   output logic                 hit,
   output logic [IDX_W-1:0]     hit_idx,
   output logic [CountBits-1:0] hit_count
);

   // stage 0: overlap extents
   logic [CoordBits-1:0] min_x2, max_x1, min_y2, max_y1;
   logic [CoordBits:0]   dw, dh;
   logic [CoordBits-1:0] w_in, h_in;
   logic [AreaBits:0]    asum_in;

   // stage 1 registers
   logic                 s1_valid_ff;
   logic [CoordBits-1:0] s1_w_ff, s1_h_ff;
   logic [AreaBits:0]    s1_asum_ff;
   logic [IDX_W-1:0]     s1_idx_ff;
   logic [CountBits-1:0] s1_count_ff;

   // stage 2 registers
   logic                   s2_valid_ff;
   logic [2*CoordBits-1:0] s2_inter_ff;
   logic [AreaBits:0]      s2_asum_ff;
   logic [IDX_W-1:0]       s2_idx_ff;
   logic [CountBits-1:0]   s2_count_ff;

   logic signed [WideBits-1:0] uni, five;

   always_comb begin
      min_x2 = (head.x2 < cand.x2) ? head.x2 : cand.x2;
      max_x1 = (head.x1 > cand.x1) ? head.x1 : cand.x1;
      min_y2 = (head.y2 < cand.y2) ? head.y2 : cand.y2;
      max_y1 = (head.y1 > cand.y1) ? head.y1 : cand.y1;
      dw = {1'b0, min_x2} - {1'b0, max_x1};
      dh = {1'b0, min_y2} - {1'b0, max_y1};
      // negative extent clamps to no overlap
      w_in = dw[CoordBits] ? '0 : dw[CoordBits-1:0];
      h_in = dh[CoordBits] ? '0 : dh[CoordBits-1:0];
      asum_in = {head.area[AreaBits-1], head.area} + {cand.area[AreaBits-1], cand.area};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_w_ff     <= w_in;
      s1_h_ff     <= h_in;
      s1_asum_ff  <= asum_in;
      s1_idx_ff   <= idx_in;
      s1_count_ff <= head.count;
      s2_inter_ff <= s1_w_ff * s1_h_ff;
      s2_asum_ff  <= s1_asum_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_count_ff <= s1_count_ff;
   end

   // overlap test: union > 0 and 5*inter > union
   always_comb begin
      uni  = {{(WideBits-AreaBits-1){s2_asum_ff[AreaBits]}}, s2_asum_ff}
           - {{(WideBits-2*CoordBits){1'b0}}, s2_inter_ff};
      five = {{(WideBits-2*CoordBits-2){1'b0}}, s2_inter_ff, 2'b00}
           + {{(WideBits-2*CoordBits){1'b0}}, s2_inter_ff};
   end

   assign hit       = s2_valid_ff && (uni > 0) && (five > uni);
   assign hit_idx   = s2_idx_ff;
   assign hit_count = s2_count_ff;

endmodule

### rtl/core/iou_box_track_table_core.sv
`timescale 1ns / 1ps
// box item: from accept to result the steps are area, ring lap, pipeline drain
//   and commit; one item at a time
// frame tick: skips the area and scan steps, counts drop in the accept cycle
// reset: synchronous, clears the fill count, control and history_limit (10);
//   table cells are not cleared, entries at or above the fill count are unused

module iou_box_track_table_core
   import ibtt_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // box / tick words
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic [CoordBits-1:0] req_left_x,
   input  logic [CoordBits-1:0] req_top_y,
   input  logic [CoordBits-1:0] req_right_x,
   input  logic [CoordBits-1:0] req_bottom_y,
   // result words
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_matched,
   output logic [IdBits-1:0]    rsp_entry_id,
   output logic [CountBits-1:0] rsp_match_level,
   output logic                 rsp_table_full,
   // apb register port
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UsedW = $clog2(TABLE_DEPTH + 1);

   // control state
   state_type            state_ff, state_in;
   logic [IdxW-1:0]      step_ff, step_in;
   logic [UsedW-1:0]     used_ff;
   logic [CountBits-1:0] limit_ff;
   logic                 cmd_ff;
   logic                 found_ff;
   logic [IdxW-1:0]      m_idx_ff;
   logic [CountBits-1:0] m_cnt_ff;

   // candidate box and its area
   entry_type cand_ff;
   entry_type cand_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_matched_ff;
   logic [IdBits-1:0]    rsp_entry_id_ff;
   logic [CountBits-1:0] rsp_level_ff;
   logic                 rsp_full_ff;

   // handshakes and strobes
   logic req_fire, fire, ring_shift, tick, wr_en, scan_valid, table_is_full;
   logic csr_wr;
   logic [IdxW-1:0] wr_idx;
   entry_type       wr_data;

   // overlap pipeline outputs
   logic                 hit;
   logic [IdxW-1:0]      hit_idx;
   logic [CountBits-1:0] hit_count;

   // saturating match count
   logic [CountBits:0]   sum_cnt;
   logic [CountBits-1:0] sat_cnt;
   logic [UsedW-1:0]     id_match, id_new;

   // candidate area product
   logic [CoordBits:0]           dx, dy;
   logic signed [2*CoordBits+1:0] area_prod;

   // ring of cells, cell 0 is the head
   entry_type    cells[TABLE_DEPTH];
   cell_ctl_type ctls[TABLE_DEPTH];

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   // commit only when the result slot is free
   assign fire       = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign table_is_full = (used_ff == UsedW'(TABLE_DEPTH));
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_command ? ST_AREA : ST_FINISH;
            end
         end
         ST_AREA: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step_ff == IdxW'(TABLE_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait here until the overlap pipeline is empty
            if (step_ff == IdxW'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      ring_shift = 1'b0;
      scan_valid = 1'b0;
      tick       = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = m_idx_ff;
      step_in    = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            tick    = req_fire && !req_command;
            step_in = '0;
         end
         ST_AREA: begin
            step_in = '0;
         end
         ST_SCAN: begin
            ring_shift = 1'b1;
            scan_valid = ({{(UsedW-IdxW){1'b0}}, step_ff} < used_ff);
            step_in    = (step_ff == IdxW'(TABLE_DEPTH - 1)) ? '0 : step_ff + IdxW'(1);
         end
         ST_DRAIN: begin
            step_in = step_ff + IdxW'(1);
         end
         ST_FINISH: begin
            if (fire && cmd_ff) begin
               if (found_ff) begin
                  wr_en  = 1'b1;
                  wr_idx = m_idx_ff;
               end else if (!table_is_full) begin
                  wr_en  = 1'b1;
                  wr_idx = used_ff[IdxW-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         used_ff  <= '0;
         limit_ff <= LimitReset;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_wr && (csr_paddr[2] == CsrHistoryLimit)) begin
            limit_ff <= csr_pwdata[CountBits-1:0];
         end
         // new entry appended at the fill count
         if (fire && cmd_ff && !found_ff && !table_is_full) begin
            used_ff <= used_ff + UsedW'(1);
         end
         // first hit in insertion order wins
         if (req_fire) begin
            found_ff <= 1'b0;
         end else if (hit && !found_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   // candidate latched on accept, its area filled in during the area cycle
   always_comb begin
      cand_in       = cand_ff;
      cand_in.count = '0;
      if (req_fire) begin
         cand_in.x1 = req_left_x;
         cand_in.y1 = req_top_y;
         cand_in.x2 = req_right_x;
         cand_in.y2 = req_bottom_y;
      end
      if (state_ff == ST_AREA) begin
         cand_in.area = area_prod[AreaBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (hit && !found_ff) begin
         m_idx_ff <= hit_idx;
         m_cnt_ff <= hit_count;
      end
      if (req_fire) begin
         cmd_ff <= req_command;
      end
      cand_ff <= cand_in;
   end

   // candidate area, signed for inverted boxes
   always_comb begin
      dx = {1'b0, cand_ff.x2} - {1'b0, cand_ff.x1};
      dy = {1'b0, cand_ff.y2} - {1'b0, cand_ff.y1};
      area_prod = $signed(dx) * $signed(dy);
   end

   // count after a match, saturating at the history limit
   always_comb begin
      sum_cnt = {1'b0, m_cnt_ff} + (CountBits + 1)'(2);
      sat_cnt = (sum_cnt > {1'b0, limit_ff}) ? limit_ff : sum_cnt[CountBits-1:0];
      id_match = UsedW'(m_idx_ff) + UsedW'(1);
      id_new   = used_ff + UsedW'(1);
   end

   always_comb begin
      wr_data       = cand_ff;
      wr_data.count = found_ff ? sat_cnt : CountBits'(1);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (cmd_ff && found_ff) begin
            rsp_matched_ff  <= 1'b1;
            rsp_entry_id_ff <= IdBits'(id_match);
            rsp_level_ff    <= sat_cnt;
            rsp_full_ff     <= 1'b0;
         end else if (cmd_ff && table_is_full) begin
            rsp_matched_ff  <= 1'b0;
            rsp_entry_id_ff <= '0;
            rsp_level_ff    <= '0;
            rsp_full_ff     <= 1'b1;
         end else if (cmd_ff) begin
            rsp_matched_ff  <= 1'b0;
            rsp_entry_id_ff <= IdBits'(id_new);
            rsp_level_ff    <= CountBits'(1);
            rsp_full_ff     <= 1'b0;
         end else begin
            // frame tick reports all zero
            rsp_matched_ff  <= 1'b0;
            rsp_entry_id_ff <= '0;
            rsp_level_ff    <= '0;
            rsp_full_ff     <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_entry_id    = rsp_entry_id_ff;
   assign rsp_match_level = rsp_level_ff;
   assign rsp_table_full  = rsp_full_ff;

   assign csr_prdata = (csr_paddr[2] == CsrHistoryLimit)
                     ? {{(32-CountBits){1'b0}}, limit_ff} : 32'd0;

   // ring: each cell takes its upper neighbor, the last wraps from the head
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      always_comb begin
         ctls[i].shift = ring_shift;
         ctls[i].tick  = tick;
         ctls[i].write = wr_en && (wr_idx == IdxW'(i));
      end

      ibtt_cell u_cell (
         .clock     (clock),
         .ctl       (ctls[i]),
         .nbr_in    (cells[(i + 1) % TABLE_DEPTH]),
         .wr_data   (wr_data),
         .entry_out (cells[i])
      );
   end

   // shared overlap test on the head cell
   ibtt_iou #(
      .IDX_W (IdxW)
   ) u_iou (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (scan_valid),
      .idx_in    (step_ff),
      .head      (cells[0]),
      .cand      (cand_ff),
      .hit       (hit),
      .hit_idx   (hit_idx),
      .hit_count (hit_count)
   );

   // fill count never passes the table depth
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UsedW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   // a recorded hit always points at a filled entry
   a_hit_filled: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> ({{(UsedW-IdxW){1'b0}}, m_idx_ff} < used_ff))
      else $error("match index outside filled entries");

   // the overlap pipeline is empty when the result is committed
   a_pipe_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> !hit)
      else $error("overlap hit after the scan ended");

   // a dropped box means the table was full and nothing matched
   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd_ff && !found_ff && table_is_full) |=> (rsp_full_ff && !rsp_matched_ff))
      else $error("table full result wrong");

   // a box item starts with the area cycle
   a_box_seq: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_command) |=> (state_ff == ST_AREA))
      else $error("box item skipped area cycle");

endmodule
